@@ design/bpsb_pkg.sv @@
// ----------------------------------------------------------------------------
// bpsb_pkg
// Types and constants of the byte predicate scan to bitmap block.
// ----------------------------------------------------------------------------
package bpsb_pkg;

	localparam int unsigned WORD_BITS    = 64;
	localparam int unsigned OFFSET_BITS  = 6;
	localparam int unsigned ROW_BITS     = 17;
	localparam int unsigned WORD_NR_BITS = ROW_BITS - OFFSET_BITS;
	localparam int unsigned INDEX_BITS   = 10;
	localparam int unsigned COUNT_BITS   = 4;
	localparam int unsigned LANES        = 8;
	localparam int unsigned IN_TDATA_W   = 72;
	localparam int unsigned OUT_TDATA_W  = 80;
	localparam int unsigned CFG_INDEX_W  = 2;
	localparam int unsigned CFG_DATA_W   = 8;

	typedef enum logic [2:0] {
		CMP_GT = 3'd0,
		CMP_GE = 3'd1,
		CMP_LT = 3'd2,
		CMP_LE = 3'd3,
		CMP_EQ = 3'd4,
		CMP_NE = 3'd5
	} cmp_op_t;

	typedef enum logic [1:0] {
		MRG_SET = 2'd0,
		MRG_AND = 2'd1,
		MRG_OR  = 2'd2
	} merge_op_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_COMPARE_OP    = 2'd0,
		REG_MERGE_OP      = 2'd1,
		REG_SIGNED_MODE   = 2'd2,
		REG_COMPARE_VALUE = 2'd3
	} reg_index_t;

	function automatic logic byte_match(input logic [7:0] a, input logic [7:0] b,
			input logic [2:0] op);
		logic r;
		r = 1'b0;
		unique case (op)
			CMP_GT:  r = a > b;
			CMP_GE:  r = a >= b;
			CMP_LT:  r = a < b;
			CMP_LE:  r = a <= b;
			CMP_EQ:  r = a == b;
			CMP_NE:  r = a != b;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

@@ design/byte_predicate_scan_bitmap.sv @@
// ----------------------------------------------------------------------------
// byte_predicate_scan_bitmap
// Compares column bytes with a configured value and merges the match bits
// into 64-bit words of a bitmap memory, emitting each word written.
// ----------------------------------------------------------------------------
// pipeline: stage one (bitmap read), then the output register
// throughput: one request per cycle while stage one can advance, set by the
// single bitmap word read-modify-write (read on accept, merged on advance)
// reset: row count, pending bits, word address and pipeline valids cleared,
// config registers to reset values; data registers and bitmap not initialised
module byte_predicate_scan_bitmap
	import bpsb_pkg::*;
#(
	parameter int unsigned MAX_ROWS       = 65536,
	parameter int unsigned BYTES_PER_ITEM = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_INDEX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [IN_TDATA_W-1:0]    s_axis_tdata,  // data_bytes, byte_count
	input  logic                     s_axis_tlast,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic [OUT_TDATA_W-1:0]   m_axis_tdata   // word_index, match_word
);

	localparam int unsigned STORE_WORDS = MAX_ROWS / WORD_BITS;
	localparam int unsigned AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
	localparam logic [AW:0] LAST_ADDR = (AW+1)'(STORE_WORDS - 1);
	localparam logic [COUNT_BITS-1:0] BPI = COUNT_BITS'(BYTES_PER_ITEM);

	logic [2:0]             compare_op_q;
	logic [1:0]             merge_op_q;
	logic                   signed_mode_q;
	logic [7:0]             compare_value_q;

	logic [ROW_BITS-1:0]    row_q;
	logic [WORD_BITS-1:0]   pending_q;
	logic [AW-1:0]          addr_q;

	logic                   valid_s1;
	logic [AW-1:0]          addr_s1;
	logic [WORD_BITS-1:0]   pend_s1;
	logic [WORD_BITS-1:0]   mask_s1;
	logic                   fwd_s1;
	logic [WORD_BITS-1:0]   fwd_data_s1;
	logic [WORD_BITS-1:0]   rdata_s1;

	logic                   out_valid_q;
	logic [INDEX_BITS-1:0]  out_index_q;
	logic [WORD_BITS-1:0]   out_word_q;

	logic [WORD_BITS-1:0]   mem [STORE_WORDS];

	logic [63:0]            data_bytes;
	logic [COUNT_BITS-1:0]  byte_count;
	logic                   accept;
	logic                   adv_s1;
	logic [OFFSET_BITS-1:0] offset;
	logic [OFFSET_BITS:0]   room;
	logic [OFFSET_BITS:0]   cnt;
	logic [OFFSET_BITS:0]   end_off;
	logic                   full;
	logic                   emit;
	logic [7:0]             flip;
	logic [WORD_BITS-1:0]   lane_bits;
	logic [WORD_BITS-1:0]   pend_new;
	logic [WORD_BITS-1:0]   mask_new;
	logic [ROW_BITS-1:0]    row_sum;
	logic [AW-1:0]          addr_inc;
	logic [WORD_BITS-1:0]   stored;
	logic [WORD_BITS-1:0]   merged;

	assign data_bytes = s_axis_tdata[63:0];
	assign byte_count = s_axis_tdata[67:64];

	assign adv_s1        = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		offset = row_q[OFFSET_BITS-1:0];
		room   = (OFFSET_BITS+1)'(WORD_BITS) - {1'b0, offset};
		cnt    = (byte_count > BPI) ? (OFFSET_BITS+1)'(BPI) : (OFFSET_BITS+1)'(byte_count);
		if (cnt > room) begin
			cnt = room;
		end
		end_off = {1'b0, offset} + cnt;
		full    = (cnt != '0) && (end_off == (OFFSET_BITS+1)'(WORD_BITS));
		emit    = full || (s_axis_tlast && (end_off != '0));
		flip    = signed_mode_q ? 8'h80 : 8'h00;
		lane_bits = '0;
		for (int k = 0; k < LANES; k++) begin
			if ((k < BYTES_PER_ITEM) && ((OFFSET_BITS+1)'(k) < cnt)) begin
				lane_bits[k] = byte_match(data_bytes[8*k +: 8] ^ flip,
					compare_value_q ^ flip, compare_op_q);
			end
		end
		pend_new = pending_q | (lane_bits << offset);
		mask_new = ~({WORD_BITS{1'b1}} << end_off);
		row_sum  = row_q + ROW_BITS'(cnt);
		addr_inc = ({1'b0, addr_q} == LAST_ADDR) ? '0 : addr_q + AW'(1);
	end

	always_comb begin
		stored = fwd_s1 ? fwd_data_s1 : rdata_s1;
		unique case (merge_op_q)
			MRG_SET: merged = pend_s1 & mask_s1;
			MRG_AND: merged = stored & (pend_s1 | ~mask_s1);
			MRG_OR:  merged = stored | (pend_s1 & mask_s1);
			default: merged = stored;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			rdata_s1 <= mem[addr_q];
		end
		if (adv_s1) begin
			mem[addr_s1] <= merged;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			addr_s1     <= addr_q;
			pend_s1     <= pend_new;
			mask_s1     <= mask_new;
			fwd_s1      <= adv_s1 && (addr_s1 == addr_q);
			fwd_data_s1 <= merged;
		end
		if (adv_s1) begin
			out_index_q <= INDEX_BITS'({{(INDEX_BITS+1){1'b0}}, addr_s1});
			out_word_q  <= merged;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compare_op_q    <= CMP_GT;
			merge_op_q      <= MRG_SET;
			signed_mode_q   <= 1'b1;
			compare_value_q <= '0;
			row_q           <= '0;
			pending_q       <= '0;
			addr_q          <= '0;
			valid_s1        <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (reg_index_t'(cfg_index))
					REG_COMPARE_OP:    compare_op_q    <= cfg_data[2:0];
					REG_MERGE_OP:      merge_op_q      <= cfg_data[1:0];
					REG_SIGNED_MODE:   signed_mode_q   <= cfg_data[0];
					REG_COMPARE_VALUE: compare_value_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				if (s_axis_tlast) begin
					row_q     <= '0;
					pending_q <= '0;
					addr_q    <= '0;
				end else begin
					row_q     <= row_sum;
					pending_q <= emit ? '0 : pend_new;
					if (full) begin
						addr_q <= (row_sum[ROW_BITS-1:OFFSET_BITS] == '0) ? '0 : addr_inc;
					end
				end
			end
			if (accept && emit) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, out_word_q, out_index_q};

endmodule
